/* src/rzfm_pkg.sv */
// rzfm_pkg: shared types and constants for the RMS / zero-crossing meter.
// No dependencies.
package rzfm_pkg;
  localparam int SampleWidth = 16;
  localparam int SumWidth    = 47;
  localparam int RmsWidth    = 15;
  localparam int PeriodWidth = 16;
  localparam int FreqWidth   = 24;
  localparam int CfgWidth    = 24;
  localparam int CfgIdxWidth = 2;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_HALF_LIM  = 2'd2,
    REG_RATE      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FEW       = 2'd1,
    ST_HALF_LONG = 2'd2
  } meas_status_t;

  typedef struct packed {
    logic [RmsWidth-1:0]    rms_level;
    logic [PeriodWidth-1:0] period_samples;
    logic [FreqWidth-1:0]   frequency_hz;
    logic [1:0]             status;
  } result_t;
endpackage

/* src/rzfm_stream_if.sv */
// rzfm_stream_if: valid/ready channel carrying one payload type.
// Depends on nothing; payload type is a parameter.
interface rzfm_stream_if #(parameter type payload_t = logic [15:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/rms_and_zero_crossing_frequency_meter.sv */
// RMS and zero-crossing frequency meter.
// Input channel in_s carries one signed q15 sample per beat; output channel
// out_s carries one result per window: rms_level, period_samples,
// frequency_hz, status. Config port: cfg_we / cfg_idx / cfg_data; the user
// must write it only while idle, as the block does not enforce this.
// Sequence: a sample that does not close a window is accepted, then put
// through the square/accumulate/crossing step. The last sample of a
// window also runs the shift-subtract steps: the mean (47 divide steps,
// then saturate), the square root (16 steps, then period select) and
// sample_rate / period (load, 24 steps, result); then the result is
// offered, and the next sample is taken once the receiver has taken it.
// The mean and frequency divides share one restoring subtractor; the
// square root has its own.
// in_s.ready is low while a sample or a window close is in progress, and
// while a result waits in the output register (receiver stall).
// Reset clears state, sum, index and crossing count; reloads defaults.
// Crossing positions are undefined until written.
module rms_and_zero_crossing_frequency_meter #(
  parameter int INDEX_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  rzfm_stream_if.sink   in_s,
  rzfm_stream_if.source out_s,
  input  logic                          cfg_we,
  input  logic [rzfm_pkg::CfgIdxWidth-1:0] cfg_idx,
  input  logic [rzfm_pkg::CfgWidth-1:0] cfg_data
);
  import rzfm_pkg::*;

  localparam int LenW = INDEX_BITS + 1;
  localparam logic [LenW-1:0] LenCap = LenW'(1) << INDEX_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_MEAN, S_ROOT, S_FREQ, S_OUT
  } state_t;

  state_t state;
  logic signed [SampleWidth-1:0] threshold, cur, previous_sample;
  logic [15:0] window_length, half_cycle_limit;
  logic [FreqWidth-1:0] sample_rate_hz;
  logic [SumWidth-1:0] square_sum;
  logic [INDEX_BITS-1:0] sample_index;
  logic seeking_down;
  logic [1:0] crossing_count;
  logic [INDEX_BITS-1:0] pos0, pos1, pos2;
  // shared shift-subtract unit
  logic [SumWidth-1:0] quo;
  logic [SumWidth:0]   rem;
  logic [5:0] step;
  logic [31:0] rx, rr, rbit;
  logic [PeriodWidth-1:0] period;
  logic [1:0] status;
  result_t res;

  logic [LenW-1:0] eff_len;
  logic [LenW-1:0] win_raw;
  assign win_raw = LenW'(window_length);
  always_comb begin
    eff_len = win_raw;
    if (win_raw < LenW'(2)) eff_len = LenW'(2);
    if (win_raw > LenCap) eff_len = LenCap;
  end

  logic signed [31:0] sq;
  assign sq = cur * cur;
  logic hit;
  always_comb begin
    if (seeking_down) hit = (previous_sample < threshold) && (cur < threshold);
    else hit = (previous_sample > threshold) && (cur > threshold);
  end

  // restoring divide step, dividend shifted in MSB first
  logic [SumWidth:0] rem_sh;
  logic [SumWidth:0] div_d;
  always_comb begin
    div_d = (state == S_MEAN) ? (SumWidth+1)'(eff_len) : (SumWidth+1)'(period);
    rem_sh = {rem[SumWidth-1:0], quo[SumWidth-1]};
  end
  logic [31:0] rsum;
  assign rsum = rr + rbit;

  logic [PeriodWidth:0] h, p2;
  logic [PeriodWidth-1:0] mask_last;
  assign h = {1'b0, PeriodWidth'(pos1 - pos0)};
  assign p2 = h << 1;
  assign mask_last = '0;

  assign in_s.ready = (state == S_IDLE);
  assign out_s.valid = (state == S_OUT);
  assign out_s.data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      threshold <= '0;
      window_length <= 16'd1024;
      half_cycle_limit <= 16'd512;
      sample_rate_hz <= 24'd1000000;
      square_sum <= '0;
      sample_index <= '0;
      previous_sample <= '0;
      seeking_down <= 1'b0;
      crossing_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_THRESHOLD: threshold <= cfg_data[SampleWidth-1:0];
          REG_WINDOW:    window_length <= cfg_data[15:0];
          REG_HALF_LIM:  half_cycle_limit <= cfg_data[15:0];
          REG_RATE:      sample_rate_hz <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_s.valid) begin
          cur <= in_s.data;
          state <= S_ACC;
        end
        S_ACC: begin
          if (sample_index == '0) begin
            crossing_count <= '0;
            seeking_down <= cur > threshold;
          end else if (crossing_count != 2'd3 && hit) begin
            case (crossing_count)
              2'd0: pos0 <= sample_index - 1'b1;
              2'd1: pos1 <= sample_index - 1'b1;
              default: pos2 <= sample_index - 1'b1;
            endcase
            crossing_count <= crossing_count + 2'd1;
            seeking_down <= !seeking_down;
          end
          previous_sample <= cur;
          if (LenW'(sample_index) + LenW'(1) < eff_len) begin
            square_sum <= square_sum + SumWidth'(unsigned'(sq));
            sample_index <= sample_index + 1'b1;
            state <= S_IDLE;
          end else begin
            quo <= square_sum + SumWidth'(unsigned'(sq));
            rem <= '0;
            step <= 6'(SumWidth);
            square_sum <= '0;
            sample_index <= '0;
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (step == '0) begin
            // quo holds sum/len; saturate mean>>15 and set up the root
            if (|quo[SumWidth-1:30]) rx <= 32'(32767) << 15;
            else rx <= {2'b0, quo[29:15], 15'b0};
            rr <= '0;
            rbit <= 32'd1 << 30;
            step <= 6'd16;
            state <= S_ROOT;
          end else begin
            if (rem_sh >= div_d) begin
              rem <= rem_sh - div_d;
              quo <= {quo[SumWidth-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[SumWidth-2:0], 1'b0};
            end
            step <= step - 6'd1;
          end
        end
        S_ROOT: begin
          if (step == '0) begin
            // period selection
            if (crossing_count == 2'd3) begin
              period <= PeriodWidth'(pos2 - pos0);
              status <= ST_OK;
            end else if (crossing_count == 2'd2) begin
              if (h < (PeriodWidth+1)'(half_cycle_limit)) begin
                period <= (p2 > (PeriodWidth+1)'(16'hFFFF)) ? 16'hFFFF :
                          p2[PeriodWidth-1:0];
                status <= ST_OK;
              end else begin
                period <= mask_last;
                status <= ST_HALF_LONG;
              end
            end else begin
              period <= mask_last;
              status <= ST_FEW;
            end
            res.rms_level <= rr[RmsWidth-1:0];
            step <= 6'(FreqWidth + 1);
            state <= S_FREQ;
          end else begin
            if (rx >= rsum) begin
              rx <= rx - rsum;
              rr <= (rr >> 1) + rbit;
            end else begin
              rr <= rr >> 1;
            end
            rbit <= rbit >> 2;
            step <= step - 6'd1;
          end
          if (step == 6'd16) begin
            quo <= '0;
          end
        end
        S_FREQ: begin
          if (step == 6'(FreqWidth + 1)) begin
            quo <= SumWidth'(sample_rate_hz) << (SumWidth - FreqWidth);
            rem <= '0;
            step <= step - 6'd1;
          end else if (step == '0) begin
            res.period_samples <= period;
            res.status <= status;
            res.frequency_hz <= (period == '0) ? '0 : quo[FreqWidth-1:0];
            if (status != ST_OK) res.rms_level <= '0;
            state <= S_OUT;
          end else begin
            if (rem_sh >= div_d) begin
              rem <= rem_sh - div_d;
              quo <= {quo[SumWidth-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[SumWidth-2:0], 1'b0};
            end
            step <= step - 6'd1;
          end
        end
        S_OUT: if (out_s.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_s.valid |-> !in_s.ready) else $error("input taken while result pending");
  a_out_after_idle: assert property (@(posedge clk) disable iff (rst)
    (out_s.valid && out_s.ready) |=> in_s.ready) else $error("no return to idle");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_s.valid && out_s.data.status == ST_OK |-> out_s.data.period_samples != '0)
    else $error("ok status with zero period");
`endif
endmodule
